FILE: rtl/pft_pkg.sv
// ----------------------------------------------------------------------------
// pft_pkg
// Widths, stage counts and the sideband type shared by the plane-setup pipeline.
// ----------------------------------------------------------------------------
package pft_pkg;

    localparam int COORD_W      = 24;  // vertex coordinate, Q11.12
    localparam int EDGE_W       = 25;  // edge vector component
    localparam int PROD_W       = 50;  // edge product
    localparam int CROSS_W      = 51;  // cross product component
    localparam int MAG_W        = 50;  // cross product magnitude
    localparam int LOD_W        = 6;   // index of the leading one of a magnitude
    localparam int UNIT_W       = 31;  // scaled magnitude, below 2^31
    localparam int SQ_W         = 62;  // square of a scaled magnitude
    localparam int RAD_W        = 64;  // sum of squares
    localparam int ROOT_W       = 32;  // integer square root
    localparam int ISQRT_STAGES = 32;  // one root bit per stage
    localparam int NUM_W        = 63;  // divider numerator
    localparam int DEN_W        = 33;  // divider denominator
    localparam int QUO_W        = 31;  // divider quotient, at most 2^30
    localparam int DIV_STAGES   = 31;  // one quotient bit per stage
    localparam int NORM_W       = 32;  // normal component, Q1.30
    localparam int DOT_W        = 56;  // normal times coordinate
    localparam int DSUM_W       = 58;  // dot product
    localparam int RND_W        = 28;  // rounded dot product magnitude
    localparam int OFFS_W       = 25;  // plane offset, Q12.12
    localparam int FRAC_SHIFT   = 30;  // Q.42 to Q.12

    localparam logic [RND_W-1:0] OFFS_POS_MAX = RND_W'(24'hFF_FFFF);
    localparam logic [RND_W-1:0] OFFS_NEG_MAX = RND_W'(25'h100_0000);

    typedef struct packed {
        logic                      valid;
        logic                      degen;
        logic [2:0]                neg;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic [UNIT_W-1:0]         ux;
        logic [UNIT_W-1:0]         uy;
        logic [UNIT_W-1:0]         uz;
    } side_t;

endpackage

FILE: rtl/pft_isqrt.sv
// ----------------------------------------------------------------------------
// pft_isqrt
// Pipelined integer square root, floor, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module pft_isqrt
(
    input  logic                          clk,
    input  logic [pft_pkg::RAD_W-1:0]     radicand,
    output logic [pft_pkg::ROOT_W-1:0]    root
);

    localparam int N = pft_pkg::ISQRT_STAGES;

    logic [33:0]                    rem_reg  [N];
    logic [pft_pkg::ROOT_W-1:0]     root_reg [N];
    logic [pft_pkg::RAD_W-1:0]      x_reg    [N];

    logic [33:0]                    rem_next  [N];
    logic [pft_pkg::ROOT_W-1:0]     root_next [N];
    logic [pft_pkg::RAD_W-1:0]      x_next    [N];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            logic [33:0]                rem_in;
            logic [pft_pkg::ROOT_W-1:0] root_in;
            logic [pft_pkg::RAD_W-1:0]  x_in;
            logic [35:0]                r2;
            logic [35:0]                trial;
            logic                       ge;

            if (g == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign x_in    = radicand;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[g-1];
                assign root_in = root_reg[g-1];
                assign x_in    = x_reg[g-1];
            end

            // bring down the next pair of radicand bits, try root*4+1
            assign r2    = {rem_in, x_in[pft_pkg::RAD_W-1 -: 2]};
            assign trial = {2'b00, root_in, 2'b01};
            assign ge    = (r2 >= trial);

            always_comb
            begin
                rem_next[g]  = ge ? 34'(r2 - trial) : r2[33:0];
                root_next[g] = {root_in[pft_pkg::ROOT_W-2:0], ge};
                x_next[g]    = {x_in[pft_pkg::RAD_W-3:0], 2'b00};
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g]  <= rem_next[g];
                root_reg[g] <= root_next[g];
                x_reg[g]    <= x_next[g];
            end
        end
    endgenerate

    assign root = root_reg[N-1];

endmodule

FILE: rtl/pft_div.sv
// ----------------------------------------------------------------------------
// pft_div
// Pipelined restoring divider, one quotient bit per stage; quotient < 2^31.
// ----------------------------------------------------------------------------
module pft_div
(
    input  logic                          clk,
    input  logic [pft_pkg::NUM_W-1:0]     num,
    input  logic [pft_pkg::DEN_W-1:0]     den,
    output logic [pft_pkg::QUO_W-1:0]     quo
);

    localparam int N  = pft_pkg::DIV_STAGES;
    localparam int QW = pft_pkg::QUO_W;
    localparam int DW = pft_pkg::DEN_W;

    logic [DW-1:0] rem_reg [N];
    logic [QW-1:0] low_reg [N];
    logic [QW-1:0] q_reg   [N];
    logic [DW-1:0] den_reg [N];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            logic [DW-1:0] rem_in;
            logic [QW-1:0] low_in;
            logic [QW-1:0] q_in;
            logic [DW-1:0] den_in;
            logic [DW:0]   r2;
            logic          ge;

            if (g == 0)
            begin : g_first
                // upper numerator bits are already below the divisor
                assign rem_in = DW'(num[pft_pkg::NUM_W-1:QW]);
                assign low_in = num[QW-1:0];
                assign q_in   = '0;
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[g-1];
                assign low_in = low_reg[g-1];
                assign q_in   = q_reg[g-1];
                assign den_in = den_reg[g-1];
            end

            assign r2 = {rem_in, low_in[QW-1]};
            assign ge = (r2 >= {1'b0, den_in});

            always_ff @(posedge clk)
            begin
                rem_reg[g] <= ge ? DW'(r2 - {1'b0, den_in}) : r2[DW-1:0];
                low_reg[g] <= {low_in[QW-2:0], 1'b0};
                q_reg[g]   <= {q_in[QW-2:0], ge};
                den_reg[g] <= den_in;
            end
        end
    endgenerate

    assign quo = q_reg[N-1];

endmodule

FILE: rtl/plane_from_three_points.sv
// ----------------------------------------------------------------------------
// plane_from_three_points
// Unit plane normal (Q1.30) and offset (Q12.12) from three Q11.12 vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the nine vertex coordinates and raise start; the transaction is
//   taken at that clock edge. busy is held low: the pipeline takes a new
//   transaction every cycle, so one triangle per clock streams through.
//   Each transaction gives one result on normal_x/y/z, plane_offset and
//   degenerate, marked by done for exactly one cycle. There are 78 register
//   stages and the first one loads at the accepting edge; done and the
//   result are registered in the last one. Results leave in the order
//   the transactions came in.
//   The stages are those of the square-root unit (32 stages, one root bit
//   each) and the three-lane divider (31 stages, one quotient bit each),
//   plus 15 stages of cross product, scaling, squaring, dot product and
//   output.
//   The receiver cannot stall; results are simply presented.
//   Collinear or coincident vertices give a zero normal and offset with
//   degenerate set.
//   Reset clears the valid bits, done and the side_t sideband registers
//   but not the datapath; no done rises before new transactions come out.
// ----------------------------------------------------------------------------
module plane_from_three_points
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [pft_pkg::COORD_W-1:0]  a_x,
    input  logic signed [pft_pkg::COORD_W-1:0]  a_y,
    input  logic signed [pft_pkg::COORD_W-1:0]  a_z,
    input  logic signed [pft_pkg::COORD_W-1:0]  b_x,
    input  logic signed [pft_pkg::COORD_W-1:0]  b_y,
    input  logic signed [pft_pkg::COORD_W-1:0]  b_z,
    input  logic signed [pft_pkg::COORD_W-1:0]  c_x,
    input  logic signed [pft_pkg::COORD_W-1:0]  c_y,
    input  logic signed [pft_pkg::COORD_W-1:0]  c_z,
    output logic                                done,
    output logic signed [pft_pkg::NORM_W-1:0]   normal_x,
    output logic signed [pft_pkg::NORM_W-1:0]   normal_y,
    output logic signed [pft_pkg::NORM_W-1:0]   normal_z,
    output logic signed [pft_pkg::OFFS_W-1:0]   plane_offset,
    output logic                                degenerate
);

    localparam int NQ = pft_pkg::ISQRT_STAGES;
    localparam int ND = pft_pkg::DIV_STAGES;

    // the pipeline never stalls
    assign busy = 1'b0;

    // ---------------- stage 1: edge vectors ----------------
    logic signed [pft_pkg::COORD_W-1:0] a_in [3];
    logic signed [pft_pkg::COORD_W-1:0] b_in [3];
    logic signed [pft_pkg::COORD_W-1:0] c_in [3];

    assign a_in[0] = a_x;
    assign a_in[1] = a_y;
    assign a_in[2] = a_z;
    assign b_in[0] = b_x;
    assign b_in[1] = b_y;
    assign b_in[2] = b_z;
    assign c_in[0] = c_x;
    assign c_in[1] = c_y;
    assign c_in[2] = c_z;

    logic                               v1_reg;
    logic signed [pft_pkg::COORD_W-1:0] a1_reg [3];
    logic signed [pft_pkg::EDGE_W-1:0]  e1_reg [3];
    logic signed [pft_pkg::EDGE_W-1:0]  e2_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            a1_reg[i] <= a_in[i];
            e1_reg[i] <= pft_pkg::EDGE_W'(b_in[i]) - pft_pkg::EDGE_W'(a_in[i]);
            e2_reg[i] <= pft_pkg::EDGE_W'(c_in[i]) - pft_pkg::EDGE_W'(a_in[i]);
        end
    end

    // ---------------- stage 2: edge products ----------------
    logic                               v2_reg;
    logic signed [pft_pkg::COORD_W-1:0] a2_reg [3];
    logic signed [pft_pkg::PROD_W-1:0]  p_reg  [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a2_reg   <= a1_reg;
        p_reg[0] <= pft_pkg::PROD_W'(e1_reg[1] * e2_reg[2]);
        p_reg[1] <= pft_pkg::PROD_W'(e1_reg[2] * e2_reg[1]);
        p_reg[2] <= pft_pkg::PROD_W'(e1_reg[2] * e2_reg[0]);
        p_reg[3] <= pft_pkg::PROD_W'(e1_reg[0] * e2_reg[2]);
        p_reg[4] <= pft_pkg::PROD_W'(e1_reg[0] * e2_reg[1]);
        p_reg[5] <= pft_pkg::PROD_W'(e1_reg[1] * e2_reg[0]);
    end

    // ---------------- stage 3: cross product ----------------
    logic                               v3_reg;
    logic signed [pft_pkg::COORD_W-1:0] a3_reg [3];
    logic signed [pft_pkg::CROSS_W-1:0] w_reg  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a3_reg <= a2_reg;
        for (int i = 0; i < 3; i++)
        begin
            w_reg[i] <= pft_pkg::CROSS_W'(p_reg[2*i]) - pft_pkg::CROSS_W'(p_reg[2*i+1]);
        end
    end

    // ---------------- stage 4: magnitudes and signs ----------------
    logic                               v4_reg;
    logic signed [pft_pkg::COORD_W-1:0] a4_reg   [3];
    logic [pft_pkg::MAG_W-1:0]          mag4_reg [3];
    logic [2:0]                         neg4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a4_reg <= a3_reg;
        for (int i = 0; i < 3; i++)
        begin
            neg4_reg[i] <= w_reg[i][pft_pkg::CROSS_W-1];
            mag4_reg[i] <= w_reg[i][pft_pkg::CROSS_W-1]
                         ? pft_pkg::MAG_W'(-w_reg[i]) : pft_pkg::MAG_W'(w_reg[i]);
        end
    end

    // ---------------- stage 5: largest magnitude, zero check ----------------
    logic [pft_pkg::MAG_W-1:0] max_xy;
    logic [pft_pkg::MAG_W-1:0] max_all;

    always_comb
    begin
        max_xy  = (mag4_reg[0] > mag4_reg[1]) ? mag4_reg[0] : mag4_reg[1];
        max_all = (mag4_reg[2] > max_xy) ? mag4_reg[2] : max_xy;
    end

    logic                               v5_reg;
    logic                               degen5_reg;
    logic signed [pft_pkg::COORD_W-1:0] a5_reg   [3];
    logic [pft_pkg::MAG_W-1:0]          mag5_reg [3];
    logic [pft_pkg::MAG_W-1:0]          m5_reg;
    logic [2:0]                         neg5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a5_reg     <= a4_reg;
        mag5_reg   <= mag4_reg;
        neg5_reg   <= neg4_reg;
        m5_reg     <= max_all;
        degen5_reg <= (max_all == '0);
    end

    // ---------------- stage 6: leading-one position ----------------
    logic [pft_pkg::LOD_W-1:0] lead_pos;

    always_comb
    begin
        lead_pos = '0;
        for (int i = 0; i < pft_pkg::MAG_W; i++)
        begin
            if (m5_reg[i])
            begin
                lead_pos = pft_pkg::LOD_W'(i);
            end
        end
    end

    logic                               v6_reg;
    logic                               degen6_reg;
    logic signed [pft_pkg::COORD_W-1:0] a6_reg   [3];
    logic [pft_pkg::MAG_W-1:0]          mag6_reg [3];
    logic [2:0]                         neg6_reg;
    logic [pft_pkg::LOD_W-1:0]          h6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else
        begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a6_reg     <= a5_reg;
        mag6_reg   <= mag5_reg;
        neg6_reg   <= neg5_reg;
        degen6_reg <= degen5_reg;
        h6_reg     <= lead_pos;
    end

    // ---------------- stage 7: scale so the largest lands in [2^30, 2^31) ----
    // (mag << 30) >> h covers both the left and the truncating right shift.
    localparam int SHW = pft_pkg::MAG_W + pft_pkg::FRAC_SHIFT;

    logic [SHW-1:0]                 shifted [3];
    pft_pkg::side_t                 s7_next;
    pft_pkg::side_t                 s7_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            shifted[i] = {mag6_reg[i], {pft_pkg::FRAC_SHIFT{1'b0}}} >> h6_reg;
        end
        s7_next.valid = v6_reg;
        s7_next.degen = degen6_reg;
        s7_next.neg   = neg6_reg;
        s7_next.ax    = a6_reg[0];
        s7_next.ay    = a6_reg[1];
        s7_next.az    = a6_reg[2];
        s7_next.ux    = shifted[0][pft_pkg::UNIT_W-1:0];
        s7_next.uy    = shifted[1][pft_pkg::UNIT_W-1:0];
        s7_next.uz    = shifted[2][pft_pkg::UNIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_reg <= '0;
        end
        else
        begin
            s7_reg <= s7_next;
        end
    end

    // ---------------- stage 8: squares ----------------
    pft_pkg::side_t            s8_reg;
    logic [pft_pkg::SQ_W-1:0]  sq_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_reg <= '0;
        end
        else
        begin
            s8_reg <= s7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg[0] <= pft_pkg::SQ_W'(s7_reg.ux * s7_reg.ux);
        sq_reg[1] <= pft_pkg::SQ_W'(s7_reg.uy * s7_reg.uy);
        sq_reg[2] <= pft_pkg::SQ_W'(s7_reg.uz * s7_reg.uz);
    end

    // ---------------- stage 9: sum of squares ----------------
    pft_pkg::side_t            s9_reg;
    logic [pft_pkg::RAD_W-1:0] sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s9_reg <= '0;
        end
        else
        begin
            s9_reg <= s8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= pft_pkg::RAD_W'(sq_reg[0]) + pft_pkg::RAD_W'(sq_reg[1])
                 + pft_pkg::RAD_W'(sq_reg[2]);
    end

    // ---------------- square root, sideband delayed alongside ----------------
    logic [pft_pkg::ROOT_W-1:0] len;
    pft_pkg::side_t             sq_dly_reg [NQ];

    pft_isqrt u_isqrt
    (
        .clk      (clk),
        .radicand (sum_reg),
        .root     (len)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NQ; k++)
            begin
                sq_dly_reg[k] <= '0;
            end
        end
        else
        begin
            sq_dly_reg[0] <= s9_reg;
            for (int k = 1; k < NQ; k++)
            begin
                sq_dly_reg[k] <= sq_dly_reg[k-1];
            end
        end
    end

    // ---------------- divider operands: (u*2^31 + L) / (2L) ----------------
    pft_pkg::side_t             sp_reg;
    logic [pft_pkg::NUM_W-1:0]  num_reg [3];
    logic [pft_pkg::DEN_W-1:0]  den_reg;
    logic [pft_pkg::UNIT_W-1:0] u_sel   [3];

    assign u_sel[0] = sq_dly_reg[NQ-1].ux;
    assign u_sel[1] = sq_dly_reg[NQ-1].uy;
    assign u_sel[2] = sq_dly_reg[NQ-1].uz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sq_dly_reg[NQ-1];
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= {len, 1'b0};
        for (int i = 0; i < 3; i++)
        begin
            num_reg[i] <= {u_sel[i], {pft_pkg::QUO_W{1'b0}}} + pft_pkg::NUM_W'(len);
        end
    end

    // ---------------- three divider lanes ----------------
    logic [pft_pkg::QUO_W-1:0] quo [3];
    pft_pkg::side_t            sd_dly_reg [ND];

    genvar ln;
    generate
        for (ln = 0; ln < 3; ln++)
        begin : g_lane
            pft_div u_div
            (
                .clk (clk),
                .num (num_reg[ln]),
                .den (den_reg),
                .quo (quo[ln])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ND; k++)
            begin
                sd_dly_reg[k] <= '0;
            end
        end
        else
        begin
            sd_dly_reg[0] <= sp_reg;
            for (int k = 1; k < ND; k++)
            begin
                sd_dly_reg[k] <= sd_dly_reg[k-1];
            end
        end
    end

    // ---------------- signed normal ----------------
    pft_pkg::side_t                     sn_reg;
    logic signed [pft_pkg::NORM_W-1:0]  n_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sn_reg <= '0;
        end
        else
        begin
            sn_reg <= sd_dly_reg[ND-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_reg[i] <= sd_dly_reg[ND-1].neg[i] ? -pft_pkg::NORM_W'(quo[i])
                                                :  pft_pkg::NORM_W'(quo[i]);
        end
    end

    // ---------------- dot product terms ----------------
    pft_pkg::side_t                     sm_reg;
    logic signed [pft_pkg::NORM_W-1:0]  nm_reg [3];
    logic signed [pft_pkg::DOT_W-1:0]   dp_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_reg <= '0;
        end
        else
        begin
            sm_reg <= sn_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nm_reg    <= n_reg;
        dp_reg[0] <= pft_pkg::DOT_W'(n_reg[0] * sn_reg.ax);
        dp_reg[1] <= pft_pkg::DOT_W'(n_reg[1] * sn_reg.ay);
        dp_reg[2] <= pft_pkg::DOT_W'(n_reg[2] * sn_reg.az);
    end

    // ---------------- dot product sum ----------------
    pft_pkg::side_t                     ss_reg;
    logic signed [pft_pkg::NORM_W-1:0]  ns_reg [3];
    logic signed [pft_pkg::DSUM_W-1:0]  dot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ss_reg <= '0;
        end
        else
        begin
            ss_reg <= sm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ns_reg  <= nm_reg;
        dot_reg <= pft_pkg::DSUM_W'(dp_reg[0]) + pft_pkg::DSUM_W'(dp_reg[1])
                 + pft_pkg::DSUM_W'(dp_reg[2]);
    end

    // ---------------- dot magnitude ----------------
    pft_pkg::side_t                     sa_reg;
    logic signed [pft_pkg::NORM_W-1:0]  na_reg [3];
    logic [pft_pkg::DSUM_W-1:0]         dmag_reg;
    logic                               dneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_reg <= '0;
        end
        else
        begin
            sa_reg <= ss_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        na_reg   <= ns_reg;
        dneg_reg <= dot_reg[pft_pkg::DSUM_W-1];
        dmag_reg <= dot_reg[pft_pkg::DSUM_W-1] ? pft_pkg::DSUM_W'(-dot_reg)
                                               : pft_pkg::DSUM_W'(dot_reg);
    end

    // ---------------- round to Q.12, negate, saturate, present ----------------
    logic [pft_pkg::DSUM_W-1:0]        rsum;
    logic [pft_pkg::RND_W-1:0]         rmag;
    logic signed [pft_pkg::OFFS_W-1:0] offs;

    always_comb
    begin
        rsum = dmag_reg + (pft_pkg::DSUM_W'(1) << (pft_pkg::FRAC_SHIFT - 1));
        rmag = rsum[pft_pkg::DSUM_W-1:pft_pkg::FRAC_SHIFT];
        if (dneg_reg)
        begin
            // negative dot gives a positive offset
            offs = (rmag > pft_pkg::OFFS_POS_MAX) ? pft_pkg::OFFS_W'(pft_pkg::OFFS_POS_MAX)
                                                  : pft_pkg::OFFS_W'(rmag);
        end
        else
        begin
            offs = (rmag > pft_pkg::OFFS_NEG_MAX) ? -pft_pkg::OFFS_W'(pft_pkg::OFFS_NEG_MAX)
                                                  : -pft_pkg::OFFS_W'(rmag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= sa_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        degenerate <= sa_reg.degen;
        if (sa_reg.degen)
        begin
            normal_x     <= '0;
            normal_y     <= '0;
            normal_z     <= '0;
            plane_offset <= '0;
        end
        else
        begin
            normal_x     <= na_reg[0];
            normal_y     <= na_reg[1];
            normal_z     <= na_reg[2];
            plane_offset <= offs;
        end
    end

endmodule
